@@ design/sfe_pkg.sv @@
// sfe_pkg: shared types and constants of the stereo feedback echo unit
// register index codes, gain configuration struct, delay ring write struct, calc result struct, gain_mul function
// no dependencies
`default_nettype none

package sfe_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int WORD_W    = 32;
    localparam int GAIN_W    = 17;
    localparam int DELAY_W   = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_DRY          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX_DELAYED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB_SAME_DRY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_SAME_DELAYED  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_CROSS_DRY     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FB_CROSS_DELAYED = 3'd7;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN    = 17'h10000;
    localparam logic [DELAY_W-1:0] DELAY_DEFAULT = 15'd1;

    typedef struct packed {
        logic              stereo_mode;
        logic [GAIN_W-1:0] mix_dry;
        logic [GAIN_W-1:0] mix_delayed;
        logic [GAIN_W-1:0] fb_same_dry;
        logic [GAIN_W-1:0] fb_same_delayed;
        logic [GAIN_W-1:0] fb_cross_dry;
        logic [GAIN_W-1:0] fb_cross_delayed;
    } gain_cfg_t;

    typedef struct packed {
        logic                en_l;
        logic                en_r;
        logic [SAMPLE_W-1:0] data_l;
        logic [SAMPLE_W-1:0] data_r;
    } ring_wr_t;

    typedef struct packed {
        logic [WORD_W-1:0]   out_left;
        logic [WORD_W-1:0]   out_right;
        logic [SAMPLE_W-1:0] fb_left;
        logic [SAMPLE_W-1:0] fb_right;
    } calc_out_t;

    // unsigned gain times signed 17-bit sample, wrapped to 32 bits
    function automatic logic [WORD_W-1:0] gain_mul(input logic [GAIN_W-1:0] g,
                                                   input logic [GAIN_W-1:0] s);
        logic signed [2*GAIN_W:0] ge;
        logic signed [2*GAIN_W:0] se;
        logic signed [2*GAIN_W:0] p;
        begin
            ge = {{(GAIN_W+1){1'b0}}, g};
            se = {{(GAIN_W+1){s[GAIN_W-1]}}, s};
            p  = ge * se;
            return p[WORD_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

@@ design/sfe_if.sv @@
// sfe_if: valid/ready stream interfaces of the stereo feedback echo unit
// sample input channel and echo output channel, no dependencies
`default_nettype none

interface sfe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mix_left;
    logic signed [31:0] mix_right;

    modport source (output valid, output mix_left, output mix_right, input ready);
    modport sink (input valid, input mix_left, input mix_right, output ready);
endinterface

interface sfe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_left;
    logic signed [31:0] out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink (input valid, input out_left, input out_right, output ready);
endinterface

`default_nettype wire

@@ design/sfe_ring.sv @@
// sfe_ring: left and right delay ring memories with clearing pass and write forwarding
// depends on sfe_pkg
`default_nettype none

module sfe_ring
    import sfe_pkg::*;
#(
    parameter int RING_DEPTH = 32768
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     rd_en,
    input  logic [(RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1)-1:0] rd_addr,
    input  ring_wr_t                                 wr,
    input  logic [(RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1)-1:0] wr_addr,
    output logic [SAMPLE_W-1:0]                      dly_l,
    output logic [SAMPLE_W-1:0]                      dly_r,
    output logic                                     busy
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    logic [SAMPLE_W-1:0] mem_l [RING_DEPTH];
    logic [SAMPLE_W-1:0] mem_r [RING_DEPTH];

    logic                clr_active_reg;
    logic [AW-1:0]       clr_addr_reg;
    logic [SAMPLE_W-1:0] rd_l_reg;
    logic [SAMPLE_W-1:0] rd_r_reg;
    logic [AW-1:0]       rd_addr_reg;
    logic [AW-1:0]       fwd_addr_reg;
    logic [SAMPLE_W-1:0] fwd_l_reg;
    logic [SAMPLE_W-1:0] fwd_r_reg;
    logic                fwd_l_valid_reg;
    logic                fwd_r_valid_reg;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem_l[clr_addr_reg] <= '0;
            mem_r[clr_addr_reg] <= '0;
        end
        else
        begin
            if (wr.en_l)
            begin
                mem_l[wr_addr] <= wr.data_l;
            end
            if (wr.en_r)
            begin
                mem_r[wr_addr] <= wr.data_r;
            end
        end
        if (rd_en)
        begin
            rd_l_reg    <= mem_l[rd_addr];
            rd_r_reg    <= mem_r[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    // last write, covers a read taken at the same edge as the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_l_valid_reg <= 1'b0;
            fwd_r_valid_reg <= 1'b0;
        end
        else if (wr.en_l)
        begin
            fwd_l_valid_reg <= 1'b1;
            fwd_r_valid_reg <= wr.en_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en_l)
        begin
            fwd_addr_reg <= wr_addr;
            fwd_l_reg    <= wr.data_l;
            fwd_r_reg    <= wr.data_r;
        end
    end

    always_comb
    begin
        dly_l = rd_l_reg;
        dly_r = rd_r_reg;
        if (fwd_addr_reg == rd_addr_reg)
        begin
            if (fwd_l_valid_reg)
            begin
                dly_l = fwd_l_reg;
            end
            if (fwd_r_valid_reg)
            begin
                dly_r = fwd_r_reg;
            end
        end
    end

    assign busy = clr_active_reg;

endmodule

`default_nettype wire

@@ design/sfe_calc.sv @@
// sfe_calc: output mix and feedback arithmetic for one sample frame
// depends on sfe_pkg
`default_nettype none

module sfe_calc
    import sfe_pkg::*;
(
    input  gain_cfg_t           cfg,
    input  logic [SAMPLE_W-1:0] sample_l,
    input  logic [SAMPLE_W-1:0] sample_r,
    input  logic [SAMPLE_W-1:0] dly_l,
    input  logic [SAMPLE_W-1:0] dly_r,
    output calc_out_t           res
);

    logic [GAIN_W-1:0] sl;
    logic [GAIN_W-1:0] sr;
    logic [GAIN_W-1:0] dl;
    logic [GAIN_W-1:0] dr;
    logic [GAIN_W-1:0] dl1;
    logic [GAIN_W-1:0] dr1;
    logic [GAIN_W-1:0] cross_dry;
    logic [GAIN_W-1:0] cross_dly;
    logic [WORD_W-1:0] fl;
    logic [WORD_W-1:0] fr;

    assign sl  = {sample_l[SAMPLE_W-1], sample_l};
    assign sr  = {sample_r[SAMPLE_W-1], sample_r};
    assign dl  = {dly_l[SAMPLE_W-1], dly_l};
    assign dr  = {dly_r[SAMPLE_W-1], dly_r};
    assign dl1 = dl + GAIN_W'(1);
    assign dr1 = dr + GAIN_W'(1);

    // cross terms only in stereo
    assign cross_dry = cfg.stereo_mode ? cfg.fb_cross_dry : '0;
    assign cross_dly = cfg.stereo_mode ? cfg.fb_cross_delayed : '0;

    assign fl = gain_mul(cfg.fb_same_delayed, dl1) + gain_mul(cross_dly, dr1)
              + gain_mul(cfg.fb_same_dry, sl) + gain_mul(cross_dry, sr);
    assign fr = gain_mul(cross_dly, dl1) + gain_mul(cfg.fb_same_delayed, dr1)
              + gain_mul(cross_dry, sl) + gain_mul(cfg.fb_same_dry, sr);

    always_comb
    begin
        res.out_left = gain_mul(cfg.mix_dry, sl) + gain_mul(cfg.mix_delayed, dl);
        if (cfg.stereo_mode)
        begin
            res.out_right = gain_mul(cfg.mix_dry, sr) + gain_mul(cfg.mix_delayed, dr);
        end
        else
        begin
            res.out_right = '0;
        end
        res.fb_left  = fl[WORD_W-1:SAMPLE_W];
        res.fb_right = fr[WORD_W-1:SAMPLE_W];
    end

endmodule

`default_nettype wire

@@ design/stereo_feedback_echo_unit.sv @@
// stereo_feedback_echo_unit: feedback echo on a stereo stream of 32-bit mix words
// depends on sfe_pkg, sfe_if, sfe_ring, sfe_calc
//
// samples carries mix_left/mix_right frames in, echoes carries out_left/out_right out,
// both valid/ready; a transfer happens when valid and ready are high at a clock edge.
// cfg_wr_en/cfg_index/cfg_data write one configuration register per edge; write only
// while no frame is in flight.
// a frame taken at the input is registered in the s1 stage, then in the output register
// throughput: one frame per cycle unless echoes stalls; the read of the delay ring is
// issued at the input transfer, its registered data meets the frame in the s1 stage,
// and the feedback word is written back when the frame moves into the output register
// reset: configuration returns to defaults and both rings are cleared by a pass over
// all RING_DEPTH entries, one entry per cycle, during which samples.ready stays low
// stall: when echoes.ready is low the output register holds, one more frame may sit
// in the ring read stage, then samples.ready drops until the output is taken
`default_nettype none

module stereo_feedback_echo_unit
    import sfe_pkg::*;
#(
    parameter int RING_DEPTH = 32768
) (
    input  logic                 clk,
    input  logic                 rst_n,
    sfe_in_if.sink               samples,
    sfe_out_if.source            echoes,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int DW = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
    localparam logic [DW-1:0] DEPTH_W   = DW'(RING_DEPTH);
    localparam logic [DW-1:0] MAX_DELAY = DW'(RING_DEPTH - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

    gain_cfg_t            gain_reg;
    logic [DELAY_W-1:0]   delay_reg;

    logic [AW-1:0]        wp_reg;
    logic [AW-1:0]        wp_next;
    logic                 s1_valid_reg;
    logic [SAMPLE_W-1:0]  s1_sl_reg;
    logic [SAMPLE_W-1:0]  s1_sr_reg;
    logic [AW-1:0]        s1_wp_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_W-1:0]    out_left_reg;
    logic [WORD_W-1:0]    out_right_reg;

    logic                 ring_busy;
    logic                 s1_go;
    logic                 in_take;
    logic [DW-1:0]        d_ext;
    logic [DW-1:0]        d_sat;
    logic [DW-1:0]        wp_ext;
    logic [DW-1:0]        rd_sum;
    logic [AW-1:0]        rd_addr;
    logic [SAMPLE_W-1:0]  dly_l;
    logic [SAMPLE_W-1:0]  dly_r;
    ring_wr_t             ring_wr;
    calc_out_t            calc_res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg.stereo_mode      <= 1'b0;
            delay_reg                 <= DELAY_DEFAULT;
            gain_reg.mix_dry          <= UNITY_GAIN;
            gain_reg.mix_delayed      <= '0;
            gain_reg.fb_same_dry      <= '0;
            gain_reg.fb_same_delayed  <= '0;
            gain_reg.fb_cross_dry     <= '0;
            gain_reg.fb_cross_delayed <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_STEREO_MODE:      gain_reg.stereo_mode      <= cfg_data[0];
                REG_DELAY_SAMPLES:    delay_reg                 <= cfg_data[DELAY_W-1:0];
                REG_MIX_DRY:          gain_reg.mix_dry          <= cfg_data[GAIN_W-1:0];
                REG_MIX_DELAYED:      gain_reg.mix_delayed      <= cfg_data[GAIN_W-1:0];
                REG_FB_SAME_DRY:      gain_reg.fb_same_dry      <= cfg_data[GAIN_W-1:0];
                REG_FB_SAME_DELAYED:  gain_reg.fb_same_delayed  <= cfg_data[GAIN_W-1:0];
                REG_FB_CROSS_DRY:     gain_reg.fb_cross_dry     <= cfg_data[GAIN_W-1:0];
                REG_FB_CROSS_DELAYED: gain_reg.fb_cross_delayed <= cfg_data[GAIN_W-1:0];
                default:              ;
            endcase
        end
    end

    // handshake
    assign s1_go          = s1_valid_reg && (!out_valid_reg || echoes.ready);
    assign samples.ready  = !ring_busy && (!s1_valid_reg || s1_go);
    assign in_take        = samples.valid && samples.ready;
    assign out_valid_next = s1_go || (out_valid_reg && !echoes.ready);

    // read position, delay limited to 1 .. RING_DEPTH-1
    assign d_ext  = DW'(delay_reg);
    assign d_sat  = (d_ext == '0) ? DW'(1) : ((d_ext > MAX_DELAY) ? MAX_DELAY : d_ext);
    assign wp_ext = DW'(wp_reg);
    assign rd_sum = (wp_ext >= d_sat) ? (wp_ext - d_sat) : (wp_ext + DEPTH_W - d_sat);
    assign rd_addr = rd_sum[AW-1:0];
    assign wp_next = (wp_reg == LAST_ADDR) ? '0 : wp_reg + AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                wp_reg <= wp_next;
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sl_reg <= samples.mix_left[WORD_W-1:SAMPLE_W];
            s1_sr_reg <= samples.mix_right[WORD_W-1:SAMPLE_W];
            s1_wp_reg <= wp_reg;
        end
        if (s1_go)
        begin
            out_left_reg  <= calc_res.out_left;
            out_right_reg <= calc_res.out_right;
        end
    end

    assign ring_wr.en_l   = s1_go;
    assign ring_wr.en_r   = s1_go && gain_reg.stereo_mode;
    assign ring_wr.data_l = calc_res.fb_left;
    assign ring_wr.data_r = calc_res.fb_right;

    sfe_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_take),
        .rd_addr (rd_addr),
        .wr      (ring_wr),
        .wr_addr (s1_wp_reg),
        .dly_l   (dly_l),
        .dly_r   (dly_r),
        .busy    (ring_busy)
    );

    sfe_calc u_calc (
        .cfg      (gain_reg),
        .sample_l (s1_sl_reg),
        .sample_r (s1_sr_reg),
        .dly_l    (dly_l),
        .dly_r    (dly_r),
        .res      (calc_res)
    );

    assign echoes.valid     = out_valid_reg;
    assign echoes.out_left  = out_left_reg;
    assign echoes.out_right = out_right_reg;

endmodule

`default_nettype wire

@@ design/sfe_chk.sv @@
// sfe_chk: port-level assertions for stereo_feedback_echo_unit, bound to the top level
// no dependencies
`default_nettype none

module sfe_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_left,
    input logic [31:0] out_right,
    input logic        cfg_wr_en,
    input logic [2:0]  cfg_index,
    input logic        cfg_bit0
);

    localparam logic [2:0] IDX_STEREO = 3'd0;

    logic       stereo_reg;
    logic [1:0] flight_reg;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_reg <= 1'b0;
            flight_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index == IDX_STEREO))
            begin
                stereo_reg <= cfg_bit0;
            end
            flight_reg <= flight_reg + {1'b0, in_xfer} - {1'b0, out_xfer};
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
        else $error("echo output changed while stalled");

    a_mono_right: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stereo_reg |-> out_right == 32'd0)
        else $error("right output nonzero in mono");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> flight_reg != 2'd0)
        else $error("echo without a pending sample frame");

    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("input ready during ring clearing");

    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg == 2'd2 && !out_ready |-> !in_ready)
        else $error("input taken with both stages full");

endmodule

bind stereo_feedback_echo_unit sfe_chk u_sfe_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (echoes.valid),
    .out_ready (echoes.ready),
    .out_left  (echoes.out_left),
    .out_right (echoes.out_right),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_bit0  (cfg_data[0])
);

`default_nettype wire
